// ----- sv/tdr_pkg.sv -----
package tdr_pkg;

    localparam int TABLE_DEPTH_DEF = 256;
    localparam int TAG_WIDTH_DEF   = 32;
    localparam int IN_TAG_WIDTH    = 32;
    localparam int CODE_WIDTH      = 8;

endpackage

// ----- sv/tdr_ram.sv -----
module tdr_ram #(
    parameter int WIDTH = tdr_pkg::TAG_WIDTH_DEF,
    parameter int DEPTH = tdr_pkg::TABLE_DEPTH_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/tag_dense_renumbering_top.sv -----
// Each accepted item is compared against the N keys of its set, one entry per cycle; a hit
// at entry j ends the scan there, a miss scans all N. A new item is taken only once the last
// has left S_DONE (o_stall is high outside S_IDLE); the key table is read through the single
// read port of the table RAM, one shared comparator. An output stall holds the result in S_DONE.
// Reset (i_rst_n low, synchronous) empties the table count and drops output valid.
// The key RAM itself is not cleared; only entries below the count are compared.
module tag_dense_renumbering_top #(
    parameter int TABLE_DEPTH = tdr_pkg::TABLE_DEPTH_DEF,
    parameter int TAG_WIDTH   = tdr_pkg::TAG_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic signed [tdr_pkg::IN_TAG_WIDTH-1:0] i_tag_value,
    input  logic                             i_start_of_set,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [tdr_pkg::CODE_WIDTH-1:0]   o_dense_code,
    output logic                             o_is_new,
    output logic                             o_overflow
);

    localparam int IN_W = tdr_pkg::IN_TAG_WIDTH;
    localparam int CW   = tdr_pkg::CODE_WIDTH;
    localparam int AW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int NW   = $clog2(TABLE_DEPTH + 1);
    localparam logic [NW-1:0] FULL = NW'(TABLE_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state            r_state, n_state;
    logic [NW-1:0]     r_count, n_count;
    logic [NW-1:0]     r_ridx, n_ridx;
    logic [AW-1:0]     r_cidx, n_cidx;
    logic              r_cvld, n_cvld;
    logic [TAG_WIDTH-1:0] r_key, n_key;
    logic [AW-1:0]     r_code, n_code;
    logic              r_new, n_new;
    logic              r_ovf, n_ovf;
    logic              r_ovalid, n_ovalid;
    logic [CW-1:0]     r_ocode, n_ocode;
    logic              r_onew, n_onew;
    logic              r_oovf, n_oovf;

    logic [TAG_WIDTH-1:0] w_key;
    logic [TAG_WIDTH-1:0] w_rdata;
    logic [CW-1:0]        w_code_ext;
    logic                 w_we;
    logic                 w_accept;
    logic                 w_out_free;
    logic                 w_hit;

    generate
        if (TAG_WIDTH <= IN_W) begin : g_key_narrow
            assign w_key = i_tag_value[TAG_WIDTH-1:0];
        end else begin : g_key_wide
            assign w_key = {{(TAG_WIDTH-IN_W){i_tag_value[IN_W-1]}}, i_tag_value};
        end
        if (AW >= CW) begin : g_code_trunc
            assign w_code_ext = r_code[CW-1:0];
        end else begin : g_code_ext
            assign w_code_ext = {{(CW-AW){1'b0}}, r_code};
        end
    endgenerate

    tdr_ram #(
        .WIDTH(TAG_WIDTH),
        .DEPTH(TABLE_DEPTH)
    ) u_keys (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(r_count[AW-1:0]),
        .i_wdata(r_key),
        .i_raddr(r_ridx[AW-1:0]),
        .o_rdata(w_rdata)
    );

    assign o_stall    = (r_state != S_IDLE);
    assign w_accept   = i_valid && (r_state == S_IDLE);
    assign w_out_free = !r_ovalid || !i_stall;
    assign w_hit      = r_cvld && (w_rdata == r_key);
    assign w_we       = (r_state == S_SCAN) && !w_hit && !r_cvld
                        && (r_ridx >= r_count) && (r_count < FULL);

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_ridx   = r_ridx;
        n_cidx   = r_cidx;
        n_cvld   = 1'b0;
        n_key    = r_key;
        n_code   = r_code;
        n_new    = r_new;
        n_ovf    = r_ovf;
        n_ovalid = r_ovalid;
        n_ocode  = r_ocode;
        n_onew   = r_onew;
        n_oovf   = r_oovf;

        if (r_ovalid && !i_stall) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_key   = w_key;
                    n_ridx  = '0;
                    n_state = S_SCAN;
                    if (i_start_of_set) begin
                        n_count = '0;
                    end
                end
            end
            S_SCAN: begin
                if (w_hit) begin
                    n_code  = r_cidx;
                    n_new   = 1'b0;
                    n_ovf   = 1'b0;
                    n_state = S_DONE;
                end else if (r_ridx < r_count) begin
                    n_cvld = 1'b1;
                    n_cidx = r_ridx[AW-1:0];
                    n_ridx = r_ridx + NW'(1);
                end else if (!r_cvld) begin
                    n_state = S_DONE;
                    if (r_count < FULL) begin
                        n_code  = r_count[AW-1:0];
                        n_new   = 1'b1;
                        n_ovf   = 1'b0;
                        n_count = r_count + NW'(1);
                    end else begin
                        n_code = '0;
                        n_new  = 1'b0;
                        n_ovf  = 1'b1;
                    end
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_ovalid = 1'b1;
                    n_ocode  = w_code_ext;
                    n_onew   = r_new;
                    n_oovf   = r_ovf;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_cvld   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_cvld   <= n_cvld;
            r_ovalid <= n_ovalid;
        end
        r_ridx  <= n_ridx;
        r_cidx  <= n_cidx;
        r_key   <= n_key;
        r_code  <= n_code;
        r_new   <= n_new;
        r_ovf   <= n_ovf;
        r_ocode <= n_ocode;
        r_onew  <= n_onew;
        r_oovf  <= n_oovf;
    end

    assign o_valid      = r_ovalid;
    assign o_dense_code = r_ocode;
    assign o_is_new     = r_onew;
    assign o_overflow   = r_oovf;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL)
        else $error("key count beyond table depth");

    a_ovf_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_overflow) |-> (o_dense_code == '0 && !o_is_new))
        else $error("overflow result carries a code");

    a_scan_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_ridx <= r_count))
        else $error("scan index past key count");

    a_insert_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |=> (r_count == $past(r_count) + NW'(1)) && (r_state == S_DONE) && r_new)
        else $error("insert did not advance the key count");

    a_idle_no_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_cvld)
        else $error("compare pending while idle");

endmodule
